// ----- rtl/orma_pkg.sv -----
// Shared constants, command and status types, and constant dividers for the moving average.
`timescale 1ns / 1ps
`default_nettype none

package orma_pkg;

	// Window depth and sample width.
	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 12;
	// The band is plus or minus one tenth of the window average.
	localparam int BAND_DIV    = 10;

	localparam int IDX_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
	localparam int REM_W  = CNT_W + 1;
	localparam int STEP_W = $clog2(SAMPLE_BITS);
	localparam int BAND_W = SAMPLE_BITS + 1;

	// Division of the window sum by WINDOW through a rounded-up reciprocal,
	// exact for every sum below 2**SUM_W.
	localparam int AVG_SHIFT   = SUM_W + $clog2(WINDOW);
	localparam int AVG_RECIP_W = SUM_W + 1;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
		AVG_RECIP_W'(((longint'(1) << AVG_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

	// Division of a band operand by BAND_DIV, exact below 2**BAND_W.
	localparam int BAND_SHIFT   = BAND_W + $clog2(BAND_DIV);
	localparam int BAND_RECIP_W = BAND_W + 1;
	localparam int BAND_Q_W     = BAND_W + BAND_RECIP_W - BAND_SHIFT;
	localparam logic [BAND_RECIP_W-1:0] BAND_RECIP =
		BAND_RECIP_W'(((longint'(1) << BAND_SHIFT) + longint'(BAND_DIV) - 1)
		/ longint'(BAND_DIV));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_BAND,
		ST_SCAN,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             take;
		logic             avg;
		logic             band;
		logic             scan;
		logic [IDX_W-1:0] idx;
		logic             div_init;
		logic             div_step;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
	} sts_t;

	function automatic logic [SAMPLE_BITS-1:0] avg_of(input logic [SUM_W-1:0] sum);
		logic [SUM_W+AVG_RECIP_W-1:0] prod;
		prod = {{AVG_RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, AVG_RECIP};
		return prod[AVG_SHIFT +: SAMPLE_BITS];
	endfunction

	function automatic logic [BAND_Q_W-1:0] band_div(input logic [BAND_W-1:0] v);
		logic [BAND_W+BAND_RECIP_W-1:0] prod;
		prod = {{BAND_RECIP_W{1'b0}}, v} * {{BAND_W{1'b0}}, BAND_RECIP};
		return prod[BAND_W+BAND_RECIP_W-1:BAND_SHIFT];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/orma_in_if.sv -----
// Request channel that carries one sample.
`timescale 1ns / 1ps
`default_nettype none

interface orma_in_if;
	import orma_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/orma_out_if.sv -----
// Request channel that carries one filtered result.
`timescale 1ns / 1ps
`default_nettype none

interface orma_out_if;
	import orma_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] filtered;
	logic                   held;

	modport source (output valid, output filtered, output held, input ready);
	modport sink (input valid, input filtered, input held, output ready);
endinterface

`default_nettype wire

// ----- rtl/outlier_rejecting_moving_average_core.sv -----
// Top level of the outlier-rejecting moving average.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Samples arrive on the samples channel (valid/ready, 12-bit millivolt
// value). Each accepted request shifts the sample into a ten-entry history,
// forms the window average, a band of plus or minus one tenth around it, and
// the truncated mean of the entries strictly inside that band. One result
// request per sample leaves on the results channel with filtered and held.
// When no entry lies inside the band, the previous result is repeated with
// held set.
// Each accepted sample passes through intake, average and band, a walk
// over all ten window entries, a check, the bit-serial divider with one
// quotient bit per cycle and the load of the result register; the divider
// is skipped when the band holds no entries. A new sample is accepted only
// once the previous one has loaded its result. The result appears on
// results in the cycle after its load.
// Reset clears the history, the running sum and the last result to zero;
// no result is pending afterwards. A stalled receiver holds the result
// register; the next sample is still accepted and worked on, and waits
// only to load its own result until the previous one is taken.

module outlier_rejecting_moving_average_core (
	input  logic              clk,
	input  logic              arst_n,
	orma_in_if.sink           samples,
	orma_out_if.source        results
);
	import orma_pkg::*;

	cmd_t cmd;
	sts_t sts;

	orma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	orma_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (samples.sample),
		.sts      (sts),
		.filtered (results.filtered),
		.held     (results.held)
	);

endmodule

`default_nettype wire

// ----- rtl/orma_datapath.sv -----
// Window, running sum, band limits, in-band accumulation and serial divider.
`timescale 1ns / 1ps
`default_nettype none

module orma_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  orma_pkg::cmd_t                  cmd,
	input  logic [orma_pkg::SAMPLE_BITS-1:0] sample,
	output orma_pkg::sts_t                  sts,
	output logic [orma_pkg::SAMPLE_BITS-1:0] filtered,
	output logic                            held
);
	import orma_pkg::*;

	logic [SAMPLE_BITS-1:0] win_q [WINDOW];
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [BAND_W-1:0]      hi_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SUM_W-1:0]       acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] dvd_q;
	logic [SAMPLE_BITS-1:0] last_q;
	logic                   held_q;

	logic [SAMPLE_BITS-1:0] x;
	logic                   in_band;
	logic [BAND_W-1:0]      avg_ext;
	logic [REM_W-1:0]       trial;
	logic                   fits;

	assign x       = win_q[cmd.idx];
	assign in_band = ({1'b0, x} < hi_q) && (x > lo_q);
	assign avg_ext = {1'b0, avg_q};
	assign trial   = {rem_q[REM_W-2:0], dvd_q[SAMPLE_BITS-1]};
	assign fits    = trial >= {1'b0, cnt_q};

	assign sts.cnt_zero = (cnt_q == '0);
	assign filtered     = last_q;
	assign held         = held_q;

	// History and running sum: the sum follows the window, so it is
	// updated by the entering sample minus the one that drops out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
			sum_q  <= '0;
			last_q <= '0;
			held_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				for (int i = 0; i < WINDOW - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[WINDOW-1] <= sample;
				sum_q <= sum_q + {{(SUM_W-SAMPLE_BITS){1'b0}}, sample}
					- {{(SUM_W-SAMPLE_BITS){1'b0}}, win_q[0]};
			end
			if (cmd.out_load) begin
				held_q <= sts.cnt_zero;
				if (!sts.cnt_zero) begin
					last_q <= dvd_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.avg) begin
			avg_q <= avg_of(sum_q);
		end
		if (cmd.band) begin
			hi_q  <= avg_ext + BAND_W'(band_div(avg_ext));
			lo_q  <= avg_q - SAMPLE_BITS'(band_div(avg_ext + BAND_W'(BAND_DIV - 1)));
			acc_q <= '0;
			cnt_q <= '0;
		end else if (cmd.scan && in_band) begin
			acc_q <= acc_q + {{(SUM_W-SAMPLE_BITS){1'b0}}, x};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		// Restoring division: the quotient never exceeds the largest
		// entry, so the high part of the sum starts out as the remainder.
		if (cmd.div_init) begin
			rem_q <= REM_W'(acc_q[SUM_W-1:SAMPLE_BITS]);
			dvd_q <= acc_q[SAMPLE_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? (trial - {1'b0, cnt_q}) : trial;
			dvd_q <= {dvd_q[SAMPLE_BITS-2:0], fits};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (cnt_q < CNT_W'(WINDOW)))
		else $error("in-band count overran the window");

	a_held_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && sts.cnt_zero) |=> (held_q && $stable(last_q)))
		else $error("held result did not repeat the previous value");

endmodule

`default_nettype wire

// ----- rtl/orma_ctrl.sv -----
// Sequencer for one sample: intake, average, band, window scan, division if the band holds entries, result.
`timescale 1ns / 1ps
`default_nettype none

module orma_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  orma_pkg::sts_t sts,
	output orma_pkg::cmd_t cmd
);
	import orma_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	logic              out_vld_q;
	logic              scan_last;
	logic              step_last;

	assign scan_last = (idx_q == IDX_W'(WINDOW - 1));
	assign step_last = (step_q == STEP_W'(SAMPLE_BITS - 1));
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.scan) begin
				idx_q <= scan_last ? '0 : idx_q + IDX_W'(1);
			end
			if (cmd.div_step) begin
				step_q <= step_last ? '0 : step_q + STEP_W'(1);
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.idx   = idx_q;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.avg   = 1'b1;
				state_nxt = ST_BAND;
			end
			ST_BAND: begin
				cmd.band  = 1'b1;
				state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (scan_last) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.cnt_zero) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_nxt    = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || out_ready))
		else $error("result register loaded while still occupied");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !sts.cnt_zero)
		else $error("division started with a zero divisor");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BAND) |-> (idx_q == '0) && (step_q == '0))
		else $error("counters not at rest when a new scan begins");

endmodule

`default_nettype wire

// ----- test/orma_checker.sv -----
// Checker that predicts and compares every result of the outlier-rejecting moving average.
`timescale 1ns / 1ps

module orma_checker (
	input  logic        clk,
	input  logic        arst_n,
	orma_in_if          samples,
	orma_out_if         results,
	output int unsigned mismatches,
	output int unsigned pending
);
	import orma_pkg::*;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] filtered;
		logic                   held;
	} result_t;

	// Our own copy of the sample history and of the last band mean.
	logic [SAMPLE_BITS-1:0] history [WINDOW];
	logic [SAMPLE_BITS-1:0] last_mean;
	result_t                awaited_results [$];

	// Shifts one sample into the history and works out the result it causes.
	function automatic result_t filter_step(input logic [SAMPLE_BITS-1:0] s);
		int unsigned sum;
		int unsigned avg;
		int unsigned upper;
		int unsigned lower;
		int unsigned acc;
		int unsigned cnt;
		int          i;
		result_t     r;
		for (i = 0; i < WINDOW - 1; i++)
			history[i] = history[i + 1];
		history[WINDOW - 1] = s;
		sum = 0;
		for (i = 0; i < WINDOW; i++)
			sum += 32'(history[i]);
		avg   = sum / WINDOW;
		upper = avg + avg / BAND_DIV;
		lower = avg - (avg + BAND_DIV - 1) / BAND_DIV;
		acc   = 0;
		cnt   = 0;
		for (i = 0; i < WINDOW; i++) begin
			if (32'(history[i]) > lower && 32'(history[i]) < upper) begin
				acc += 32'(history[i]);
				cnt++;
			end
		end
		if (cnt != 0) begin
			last_mean = SAMPLE_BITS'(acc / cnt);
			r.held    = 1'b0;
		end else begin
			r.held = 1'b1;
		end
		r.filtered = last_mean;
		return r;
	endfunction

	task automatic report(input string what, input int unsigned seen, input int unsigned want);
		if (mismatches < 100)
			$display("%0t: %s (seen %0d, predicted %0d)", $realtime, what, seen, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (history[i])
				history[i] = '0;
			last_mean = '0;
			awaited_results.delete();
			pending = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (awaited_results.size() == 0) begin
					report("result request with none awaited", 32'(results.filtered), 0);
				end else begin
					want = awaited_results.pop_front();
					if (results.filtered !== want.filtered)
						report("filtered mismatch", 32'(results.filtered),
							32'(want.filtered));
					if (results.held !== want.held)
						report("held mismatch", 32'(results.held), 32'(want.held));
				end
			end
			if (samples.valid && samples.ready)
				awaited_results.push_back(filter_step(samples.sample));
			pending = awaited_results.size();
		end
	end
endmodule

// ----- test/tb_top.sv -----
// Testbench top that drives samples, throttles results and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
	import orma_pkg::*;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned pending;

	// Set by the sample driver: calm turns idling off on both sides for the
	// final stretch, hold_off_req asks the result side for one long stall.
	bit calm;
	bit hold_off_req;
	int send_idle_pct;

	orma_in_if  sample_ch ();
	orma_out_if result_ch ();

	outlier_rejecting_moving_average_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.results (result_ch)
	);

	orma_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (sample_ch),
		.results    (result_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Offers one sample request and returns at the falling edge after it was
	// taken. Valid stays high afterwards, so back-to-back requests do not drop it unless an idle gap is drawn.
	task automatic offer(input logic [SAMPLE_BITS-1:0] v);
		if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= v;
		do
			@(posedge clk);
		while (!(sample_ch.valid && sample_ch.ready));
		@(negedge clk);
	endtask

	// Clamps a computed level into the sample range.
	function automatic logic [SAMPLE_BITS-1:0] clamp(input int v);
		if (v < 0)
			return '0;
		if (v > (1 << SAMPLE_BITS) - 1)
			return '1;
		return SAMPLE_BITS'(v);
	endfunction

	// Sample side: reset, a directed opening, then random segments.
	initial begin
		logic [SAMPLE_BITS-1:0] directed [$];
		int                     sent;
		int                     seg_len;
		int                     mode;
		int                     base;
		int                     spread;
		int                     level_a;
		int                     level_b;
		int                     k;
		calm             = 1'b0;
		hold_off_req     = 1'b0;
		send_idle_pct    = 20;
		arst_n           = 1'b0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A zero sample right after reset leaves the average at zero, so the band
		// is empty and the reset value is held. Full-scale samples then pass
		// through a half-zero, half-maximum window, which also holds, until the
		// window is all maximum. Bit patterns and small values follow, where the
		// band offsets round differently up and down.
		directed = '{12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
			12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hAAA, 12'h555, 12'h800, 12'h001,
			12'h7FF, 12'd10, 12'd11, 12'd9, 12'd100, 12'd110};
		foreach (directed[i])
			offer(directed[i]);

		// Random segments. Most are clusters around a level with a few outliers,
		// which is what a sensor produces and what keeps the band populated.
		sent = 0;
		while (sent < 1500) begin
			seg_len       = $urandom_range(5, 30);
			mode          = $urandom_range(0, 9);
			base          = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
			spread        = base / 8 + 1;
			level_a       = $urandom_range(0, 1000);
			level_b       = $urandom_range(3000, (1 << SAMPLE_BITS) - 1);
			send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
			if (mode == 6) begin
				case ($urandom_range(0, 2))
					0: base = 0;
					1: base = (1 << SAMPLE_BITS) - 1;
					default: ;
				endcase
			end
			for (k = 0; k < seg_len; k++) begin
				// One long stall on the result side while requests keep coming.
				if (sent == 400)
					hold_off_req = 1'b1;
				// One pause on the sample side until every result has arrived.
				if (sent == 900) begin
					sample_ch.valid <= 1'b0;
					@(posedge clk);
					wait (pending == 0);
					@(negedge clk);
				end
				if (sent == 1300)
					calm = 1'b1;
				case (mode)
					0, 1, 2, 3, 4: begin
						if ($urandom_range(0, 9) == 0)
							offer(SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)));
						else
							offer(clamp(base + $urandom_range(0, 2 * spread) - spread));
					end
					5: offer(SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1)));
					6: offer(clamp(base));
					7: offer(SAMPLE_BITS'($urandom_range(0, 30)));
					8: offer(clamp((k % 2 == 0) ? level_a : level_b));
					default: begin
						if ($urandom_range(0, 1) == 0)
							offer(SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1));
						else
							offer(~(SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1)));
					end
				endcase
				sent++;
			end
		end

		// Drain: every predicted result must come back, then a quiet stretch
		// catches any extra result request the block might still send.
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: random stalls in bursts, stretches of steady acceptance,
	// one long hold-off on request so that the block fills and stalls its
	// input, and no stalls at all once the run turns calm.
	initial begin
		int stall_pct;
		stall_pct       = 30;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (calm) begin
				result_ch.ready <= 1'b1;
				@(negedge clk);
			end else if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off_req = 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
			if ($urandom_range(0, 19) == 0)
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
		end
	end

	// Watchdog: set far beyond the slowest legal run.
	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
